[rtl/p2g_pkg.sv]
package p2g_pkg;

    // Field widths fixed by the interface
    localparam int COORD_W = 16;
    localparam int INV_W   = 16;
    localparam int CELL_W  = 7;

    // Scaled coordinate: Q8.8 times Q8.8 gives a signed Q16.16 product
    localparam int PROD_W  = COORD_W + INV_W + 1;
    // Cell arithmetic is done at this width, wide enough for any ceil result
    localparam int IDX_W   = 20;

    localparam int DEFAULT_GRID_SIDE = 128;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [INV_W-1:0] INV_CELL_RESET = 16'd512;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_FRAME = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } back_state_t;

endpackage

[rtl/point_to_grid_first_hit.sv]
// Point-to-grid first-hit binner. Each start transaction carries an opcode and a Q8.8
// point; a point is scaled by inv_cell_size, snapped to a GRID_SIDE x GRID_SIDE cell,
// and the cell's column and row come out on result_valid the first time that cell is
// hit in a frame. Points off the grid and repeat hits give no result; a frame-start
// transaction gives none either and clears the visited bitmap. Results are strobed for
// one cycle and cannot be held off, so the receiver must take every strobe. A point
// passes the bitmap engine as a pop with a registered read of the column word, then the
// check and write-back; a frame start is the pop, then one column word cleared per cycle.
// Points dropped off the grid never reach the engine. After reset a clearing pass over
// every column word runs before the first point is checked; transactions are still
// queued meanwhile. When the engine is free a point goes through the multiply stage, a
// queue slot, the registered column-word read and the check before its result strobe is
// registered. busy is high while the 4-entry queue in front of the engine and the
// multiply stage together hold 4 transactions; start is only taken while busy is low.
// inv_cell_size may be rewritten only while the block is idle.
module point_to_grid_first_hit #(
    parameter int GRID_SIDE = p2g_pkg::DEFAULT_GRID_SIDE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command transaction
    input  logic                               start,
    output logic                               busy,
    input  logic                               opcode,
    input  logic signed [p2g_pkg::COORD_W-1:0] point_x,
    input  logic signed [p2g_pkg::COORD_W-1:0] point_y,
    // result transaction
    output logic                               result_valid,
    output logic [p2g_pkg::CELL_W-1:0]         cell_col,
    output logic [p2g_pkg::CELL_W-1:0]         cell_row,
    // configuration write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [p2g_pkg::INV_W-1:0]          cfg_data
);
    import p2g_pkg::*;

    localparam int CIW   = $clog2(GRID_SIDE);
    localparam int ENT_W = 2 * CIW + 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [INV_W-1:0] inv_cell_reg;
    logic             push;
    logic [ENT_W-1:0] push_entry;
    logic             pop;
    logic [ENT_W-1:0] head;
    logic             empty;
    logic [CNT_W-1:0] queue_count;

    // Cell-size register: always ready, written on any valid beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            inv_cell_reg <= INV_CELL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            inv_cell_reg <= cfg_data;
        end
    end

    // Front: scale, snap to a cell, drop off-grid points, queue the rest
    p2g_front #(
        .GRID_SIDE (GRID_SIDE),
        .CIW       (CIW),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .point_x       (point_x),
        .point_y       (point_y),
        .inv_cell_size (inv_cell_reg),
        .queue_count   (queue_count),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Queue decouples the front (one per cycle while busy is low) from the slower bitmap engine
    p2g_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .count     (queue_count)
    );

    // Back: clear sweeps and visited test-and-set on the bitmap memory
    p2g_back #(
        .GRID_SIDE (GRID_SIDE),
        .CIW       (CIW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .cell_col     (cell_col),
        .cell_row     (cell_row)
    );

endmodule

[rtl/p2g_front.sv]
module p2g_front #(
    parameter int GRID_SIDE = p2g_pkg::DEFAULT_GRID_SIDE,
    parameter int CIW       = $clog2(GRID_SIDE),
    parameter int CNT_W     = $clog2(p2g_pkg::QUEUE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic signed [p2g_pkg::COORD_W-1:0] point_x,
    input  logic signed [p2g_pkg::COORD_W-1:0] point_y,
    input  logic [p2g_pkg::INV_W-1:0]     inv_cell_size,
    input  logic [CNT_W-1:0]              queue_count,
    output logic                          push,
    output logic [2*CIW:0]                push_entry
);
    import p2g_pkg::*;

    localparam logic signed [IDX_W-1:0] HALF_S = IDX_W'(GRID_SIDE / 2);
    localparam logic signed [IDX_W-1:0] SIDE_S = IDX_W'(GRID_SIDE);
    localparam logic signed [IDX_W-1:0] TWO_S  = IDX_W'(2);
    localparam logic signed [PROD_W:0]  ROUND_UP = (PROD_W + 1)'(65535);
    localparam int QW = PROD_W + 1 - 16;

    logic                       accept;
    logic                       s1_valid_reg;
    logic                       s1_frame_reg;
    logic signed [PROD_W-1:0]   s1_px_reg;
    logic signed [PROD_W-1:0]   s1_py_reg;

    logic signed [PROD_W:0]     px_sum;
    logic signed [PROD_W:0]     py_sum;
    logic signed [QW-1:0]       qx;
    logic signed [QW-1:0]       qy;
    logic signed [IDX_W-1:0]    qy_adj;
    logic signed [IDX_W-1:0]    col_s;
    logic signed [IDX_W-1:0]    row_s;
    logic                       in_grid;
    logic [CNT_W:0]             occupancy;

    // Hold off while every queue slot is spoken for by a queued or in-flight transaction
    assign occupancy = {1'b0, queue_count} + (CNT_W + 1)'(s1_valid_reg);
    assign busy      = occupancy >= (CNT_W + 1)'(QUEUE_DEPTH);
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_frame_reg <= (opcode == OP_FRAME);
            s1_px_reg    <= point_x * $signed({1'b0, inv_cell_size});
            s1_py_reg    <= point_y * $signed({1'b0, inv_cell_size});
        end
    end

    // ceil(p / 2^16) is floor((p + 2^16 - 1) / 2^16) for either sign
    always_comb begin
        px_sum  = {s1_px_reg[PROD_W-1], s1_px_reg} + ROUND_UP;
        py_sum  = {s1_py_reg[PROD_W-1], s1_py_reg} + ROUND_UP;
        qx      = px_sum[PROD_W:16];
        qy      = py_sum[PROD_W:16];
        qy_adj  = IDX_W'(qy);
        if (s1_py_reg <= 0) begin
            qy_adj = IDX_W'(qy) - TWO_S;
        end
        col_s   = IDX_W'(qx) + HALF_S;
        row_s   = HALF_S - qy_adj;
        in_grid = (col_s >= 0) && (col_s < SIDE_S) && (row_s >= 0) && (row_s < SIDE_S);
    end

    // Drop points off the grid here; the back end only sees work it must do
    assign push       = s1_valid_reg && (s1_frame_reg || in_grid);
    assign push_entry = {s1_frame_reg, col_s[CIW-1:0], row_s[CIW-1:0]};

endmodule

[rtl/p2g_fifo.sv]
module p2g_fifo #(
    parameter int WIDTH = 15,
    parameter int DEPTH = p2g_pkg::QUEUE_DEPTH,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic [CNT_W-1:0] count
);
    import p2g_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

[rtl/p2g_back.sv]
module p2g_back #(
    parameter int GRID_SIDE = p2g_pkg::DEFAULT_GRID_SIDE,
    parameter int CIW       = $clog2(GRID_SIDE)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        empty,
    input  logic [2*CIW:0]              head,
    output logic                        pop,
    output logic                        result_valid,
    output logic [p2g_pkg::CELL_W-1:0]  cell_col,
    output logic [p2g_pkg::CELL_W-1:0]  cell_row
);
    import p2g_pkg::*;

    localparam logic [CIW-1:0] LAST_ROW = CIW'(GRID_SIDE - 1);

    // Visited bitmap: one word per column, one bit per row
    logic [GRID_SIDE-1:0] visited_mem [GRID_SIDE];

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [CIW-1:0]       clr_ptr_reg;
    logic [CIW-1:0]       clr_ptr_next;
    logic [CIW-1:0]       col_reg;
    logic [CIW-1:0]       row_reg;
    logic [GRID_SIDE-1:0] rd_data_reg;
    logic                 valid_reg;
    logic                 valid_next;
    logic [CELL_W-1:0]    col_out_reg;
    logic [CELL_W-1:0]    row_out_reg;

    logic                 head_frame;
    logic [CIW-1:0]       head_col;
    logic [CIW-1:0]       head_row;
    logic                 rd_en;
    logic                 wr_en;
    logic [CIW-1:0]       wr_addr;
    logic [GRID_SIDE-1:0] wr_data;
    logic                 hit;
    logic [GRID_SIDE-1:0] row_mask;
    logic [CIW+CELL_W-1:0] col_ext;
    logic [CIW+CELL_W-1:0] row_ext;

    assign head_frame = head[2*CIW];
    assign head_col   = head[2*CIW-1:CIW];
    assign head_row   = head[CIW-1:0];
    assign hit        = rd_data_reg[row_reg];
    assign row_mask   = {{(GRID_SIDE-1){1'b0}}, 1'b1} << row_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_ptr_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!empty) begin
                    state_next = head_frame ? ST_CLEAR : ST_CHECK;
                end
            end
            ST_CHECK: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        pop          = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = col_reg;
        wr_data      = rd_data_reg | row_mask;
        clr_ptr_next = clr_ptr_reg;
        valid_next   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_ptr_reg;
                wr_data      = '0;
                clr_ptr_next = (clr_ptr_reg == LAST_ROW) ? '0 : clr_ptr_reg + 1'b1;
            end
            ST_IDLE: begin
                pop   = !empty;
                rd_en = !empty && !head_frame;
            end
            ST_CHECK: begin
                wr_en      = !hit;
                valid_next = !hit;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            visited_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= visited_mem[head_col];
        end
    end

    assign col_ext = {{CELL_W{1'b0}}, col_reg};
    assign row_ext = {{CELL_W{1'b0}}, row_reg};

    always_ff @(posedge clk) begin
        if (pop) begin
            col_reg <= head_col;
            row_reg <= head_row;
        end
        if (valid_next) begin
            col_out_reg <= col_ext[CELL_W-1:0];
            row_out_reg <= row_ext[CELL_W-1:0];
        end
    end

    assign result_valid = valid_reg;
    assign cell_col     = col_out_reg;
    assign cell_row     = row_out_reg;

endmodule

[rtl/p2g_chk.sv]
module p2g_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input logic cfg_ready
);

    // The bitmap engine pops a point before it checks it, so two results never come in a row
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on back-to-back cycles");

    // Backpressure only builds up from an accepted transaction
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted transaction");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result present out of reset");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind point_to_grid_first_hit p2g_chk u_p2g_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .cfg_ready    (cfg_ready)
);
